/* rtl/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, widths and constants for the 3x3 box blur core.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

    localparam int MAX_ROW_PIXELS = 1024;
    localparam int MAX_ROWS       = 4096;

    localparam int PIX_W  = 8;
    localparam int ADDR_W = $clog2(MAX_ROW_PIXELS);
    localparam int COL_W  = $clog2(MAX_ROW_PIXELS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CSUM_W = PIX_W + 2;
    localparam int SUM_W  = PIX_W + 4;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // floor(s / 9) == (s * 7282) >> 16 for every 3x3 sum of 8-bit pixels
    localparam int DIV9_RECIP = 7282;
    localparam int DIV9_SHIFT = 16;
    localparam int PROD_W     = SUM_W + 13;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_out_item;

    // line store word: pixel two rows up, pixel one row up
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } t_lines;

    typedef struct packed {
        logic push;
        logic emit;
        logic last;
        logic write;
        logic top_v;
        logic mid_v;
        logic bot_v;
        logic left_v;
        logic right_v;
    } t_s1_ctl;

    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(DIV9_RECIP);
        return prod[DIV9_SHIFT +: PIX_W];
    endfunction

endpackage

`default_nettype wire

/* rtl/bb3_line_store.sv */
// ----------------------------------------------------------------------------
// bb3_line_store
// Two-row pixel history, one word per column, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_line_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rd_en,
    input  wire logic [bb3_pkg::ADDR_W-1:0] i_rd_addr,
    output bb3_pkg::t_lines                 o_rd_data,
    input  wire logic                       i_wr_en,
    input  wire logic [bb3_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire bb3_pkg::t_lines            i_wr_data
);

    bb3_pkg::t_lines r_mem [bb3_pkg::MAX_ROW_PIXELS];
    bb3_pkg::t_lines r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/box_blur_3x3_core.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_core
// Streaming 3x3 mean filter for 8-bit grey frames, zero outside the frame.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the output stalls; the line store
//   reads at accept and writes as the item leaves stage 1, one port each.
// Path: the completing item is registered in stage 1, then its result.
// Results lag their pixel by one row plus one pixel; flush items drain them.
// Reset: raster position cleared, geometry 640 x 480; the line store is not
//   cleared, rows not yet written in a frame are masked to zero.
`default_nettype none

module box_blur_3x3_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bb3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bb3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire bb3_pkg::t_in_item              i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bb3_pkg::t_out_item                  o_out_item
);

    localparam int COL_W  = bb3_pkg::COL_W;
    localparam int ROW_W  = bb3_pkg::ROW_W;
    localparam int PIX_W  = bb3_pkg::PIX_W;
    localparam int CSUM_W = bb3_pkg::CSUM_W;
    localparam int SUM_W  = bb3_pkg::SUM_W;
    localparam int WIDTH_BITS  = bb3_pkg::WIDTH_REG_W;
    localparam int HEIGHT_BITS = bb3_pkg::HEIGHT_REG_W;

    logic [COL_W-1:0]  r_w, n_w;
    logic [ROW_W-1:0]  r_h, n_h;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    logic              r_s1_v;
    bb3_pkg::t_s1_ctl  r_s1_ctl, n_s1_ctl;
    logic [PIX_W-1:0]  r_s1_px;
    logic [bb3_pkg::ADDR_W-1:0] r_s1_addr;

    logic [CSUM_W-1:0] r_cs_a;
    logic [CSUM_W-1:0] r_cs_b;

    logic               r_out_v;
    bb3_pkg::t_out_item r_out_item;

    logic cfg_acc, cfg_hit, in_acc, adv, drain, is_flush;
    logic [WIDTH_BITS-1:0] raw_w;
    logic [HEIGHT_BITS-1:0] raw_h;

    bb3_pkg::t_lines   rd_lines, wr_lines;
    logic              wr_en;
    logic [PIX_W-1:0]  top_px, mid_px, bot_px;
    logic [CSUM_W-1:0] cs_now, cs_left, cs_right;
    logic [SUM_W-1:0]  win_sum;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_acc && (i_cfg_index inside {bb3_pkg::REG_IMAGE_WIDTH,
                                                         bb3_pkg::REG_IMAGE_HEIGHT});
    assign adv         = !r_out_v || i_out_ready;
    assign o_in_ready  = !r_s1_v || adv;
    assign in_acc      = i_in_valid && o_in_ready;

    assign drain    = (r_row == r_h);
    assign is_flush = (i_in_item.op == bb3_pkg::OP_FLUSH);

    // Configuration: saturate the low register bits into the supported geometry
    assign raw_w = i_cfg_data[WIDTH_BITS-1:0];
    assign raw_h = i_cfg_data[HEIGHT_BITS-1:0];

    always_comb begin
        n_w = r_w;
        n_h = r_h;
        if (cfg_acc) begin
            case (i_cfg_index)
                bb3_pkg::REG_IMAGE_WIDTH: begin
                    if (32'(raw_w) < 2) begin
                        n_w = COL_W'(2);
                    end else if (32'(raw_w) > bb3_pkg::MAX_ROW_PIXELS) begin
                        n_w = COL_W'(bb3_pkg::MAX_ROW_PIXELS);
                    end else begin
                        n_w = COL_W'(raw_w);
                    end
                end
                bb3_pkg::REG_IMAGE_HEIGHT: begin
                    if (32'(raw_h) < 2) begin
                        n_h = ROW_W'(2);
                    end else if (32'(raw_h) > bb3_pkg::MAX_ROWS) begin
                        n_h = ROW_W'(bb3_pkg::MAX_ROWS);
                    end else begin
                        n_h = ROW_W'(raw_h);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Raster position and per-item control, decided at accept
    always_comb begin
        n_s1_ctl.push    = drain || !is_flush;
        n_s1_ctl.emit    = drain || (!is_flush &&
                           (r_row >= ROW_W'(2) || (r_row == ROW_W'(1) && r_col != '0)));
        n_s1_ctl.last    = drain && (r_col == r_w);
        n_s1_ctl.write   = !drain && !is_flush;
        n_s1_ctl.top_v   = (r_row >= ROW_W'(2));
        n_s1_ctl.mid_v   = (r_row != '0);
        n_s1_ctl.bot_v   = !drain;
        n_s1_ctl.left_v  = (r_col == '0) || (r_col >= COL_W'(2));
        n_s1_ctl.right_v = (r_col != '0) && (r_col < r_w);

        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (in_acc && n_s1_ctl.push) begin
            if (drain) begin
                if (r_col == r_w) begin
                    n_col = '0;
                    n_row = '0;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end else if (r_col + COL_W'(1) == r_w) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= COL_W'(bb3_pkg::WIDTH_RESET);
            r_h   <= ROW_W'(bb3_pkg::HEIGHT_RESET);
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_w   <= n_w;
            r_h   <= n_h;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    bb3_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc && n_s1_ctl.push),
        .i_rd_addr (r_col[bb3_pkg::ADDR_W-1:0]),
        .o_rd_data (rd_lines),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_lines)
    );

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc) begin
            r_s1_v <= n_s1_ctl.push;
        end else if (adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ctl  <= n_s1_ctl;
            r_s1_px   <= i_in_item.pixel_in;
            r_s1_addr <= r_col[bb3_pkg::ADDR_W-1:0];
        end
    end

    assign top_px = r_s1_ctl.top_v ? rd_lines.older : '0;
    assign mid_px = r_s1_ctl.mid_v ? rd_lines.newer : '0;
    assign bot_px = r_s1_ctl.bot_v ? r_s1_px : '0;
    assign cs_now = CSUM_W'(top_px) + CSUM_W'(mid_px) + CSUM_W'(bot_px);

    assign cs_left  = r_s1_ctl.left_v ? r_cs_a : '0;
    assign cs_right = r_s1_ctl.right_v ? cs_now : '0;
    assign win_sum  = SUM_W'(cs_left) + SUM_W'(r_cs_b) + SUM_W'(cs_right);

    assign wr_en          = r_s1_v && adv && r_s1_ctl.write;
    assign wr_lines.older = rd_lines.newer;
    assign wr_lines.newer = r_s1_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs_a <= '0;
            r_cs_b <= '0;
        end else if (r_s1_v && adv) begin
            r_cs_a <= r_cs_b;
            r_cs_b <= cs_now;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_s1_v && r_s1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_v && r_s1_ctl.emit) begin
            r_out_item.pixel_out  <= bb3_pkg::div9(win_sum);
            r_out_item.frame_last <= r_s1_ctl.last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out_item;

    // Checks
    a_recv_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < r_h) |-> (r_col < r_w))
        else $error("column past row end while receiving");

    a_drain_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == r_h) |-> (r_col <= r_w))
        else $error("drain column past final result");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !cfg_acc && drain && r_col == r_w) |=> (r_row == '0 && r_col == '0))
        else $error("raster not restarted after final result");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !adv) |=> (r_s1_v && $stable(r_s1_ctl) && $stable(r_s1_px)))
        else $error("stage 1 item lost under stall");

    a_last_is_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_ctl.last) |-> (r_s1_ctl.emit && !r_s1_ctl.write))
        else $error("frame end flagged on a non-drain item");

endmodule

`default_nettype wire
